// ----- src/bsst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsst_pkg
// shared widths and codes for the sorted-table search block
// ----------------------------------------------------------------------------
package bsst_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W       = 32;

  // request operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

endpackage

// ----- src/bsst_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsst_in_if / bsst_out_if
// valid/ready channels for search and write requests and search results
// ----------------------------------------------------------------------------
interface bsst_in_if;
  import bsst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [ADDR_W-1:0]       position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface bsst_out_if;
  import bsst_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink   (input valid, input found, input match_position, output ready);
endinterface

// ----- src/bsst_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsst_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/binary_search_sorted_table.sv -----
`timescale 1ns / 1ps
// operation: a search takes at most 11 probes for 1024 entries, none with an
//   empty table, then waits in finish for a free output register; a new
//   request is taken only back in idle; one write per cycle while idle, each
//   stored as it is taken; the probe loop is bound by the ram's registered read
// reset (synchronous, active low) clears control state and entries_r;
//   table contents are undefined until written, no clearing pass
// ----------------------------------------------------------------------------
// binary_search_sorted_table
// table of signed 32-bit entries with write requests and bisection search
// ----------------------------------------------------------------------------
module binary_search_sorted_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [bsst_pkg::CNT_W-1:0] cfg_wr_data,
  bsst_in_if.sink                    in_req,
  bsst_out_if.source                 out_rsp
);
  import bsst_pkg::*;

  // search sequencer states
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,  // waiting for a request
    ST_PROBE   = 4'b0010,  // ram read of the midpoint in flight
    ST_COMPARE = 4'b0100,  // entry back, compare against key and narrow range
    ST_FINISH  = 4'b1000   // result waits for a free output register
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    entries_r;
  logic [CNT_W-1:0]    lo_r, lo_nxt;     // first position still in range
  logic [CNT_W-1:0]    end_r, end_nxt;   // one past last position in range
  logic [ADDR_W-1:0]   mid_r, mid_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic                res_found_r, res_found_nxt;
  logic [ADDR_W-1:0]   res_pos_r, res_pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [ADDR_W-1:0]   out_pos_r, out_pos_nxt;

  logic                in_acc;
  logic                ram_we;
  logic [VAL_W-1:0]    ram_rdata;
  logic [CNT_W-1:0]    cnt_sat;
  logic                out_free;

  // midpoint floor((lo + end - 1) / 2), only used on a non-empty range
  function automatic logic [ADDR_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                               input logic [CNT_W-1:0] en);
    logic [CNT_W:0] sum;
    sum = {1'b0, lo} + {1'b0, en} - {{CNT_W{1'b0}}, 1'b1};
    return sum[ADDR_W:1];
  endfunction

  // ---------------------------------------------------------------------------
  // configuration: count of entries searched, saturated to the table depth
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  assign cnt_sat = (entries_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entries_r;

  // ---------------------------------------------------------------------------
  // table memory: written straight from write requests, read at the midpoint
  // ---------------------------------------------------------------------------
  bsst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_req.position),
    .wr_data (in_req.value),
    .rd_addr (mid_r),
    .rd_data (ram_rdata)
  );

  // requests only enter while the sequencer is idle; writes finish right away
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign ram_we       = in_acc && (in_req.operation == OP_WRITE);

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_rsp.ready;

  // ---------------------------------------------------------------------------
  // search sequencer: issue read, compare, narrow range, repeat
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    end_nxt       = end_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_req.operation == OP_SEARCH)) begin
          key_nxt = in_req.value;
          lo_nxt  = '0;
          end_nxt = cnt_sat;
          if (cnt_sat == '0) begin
            // empty table: not found without a probe
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            state_nxt     = ST_FINISH;
          end else begin
            mid_nxt   = mid_of('0, cnt_sat);
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        state_nxt = ST_COMPARE;
      end
      ST_COMPARE: begin
        if ($signed(ram_rdata) == key_r) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = mid_r;
          state_nxt     = ST_FINISH;
        end else begin
          if (key_r < $signed(ram_rdata)) begin
            end_nxt = {1'b0, mid_r};
          end else begin
            lo_nxt = {1'b0, mid_r} + CNT_W'(1);
          end
          if (lo_nxt >= end_nxt) begin
            // range emptied
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            state_nxt     = ST_FINISH;
          end else begin
            mid_nxt   = mid_of(lo_nxt, end_nxt);
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    end_r       <= end_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.found          = out_found_r;
  assign out_rsp.match_position = out_pos_r;

`ifndef SYNTHESIS
  // a probe only runs on a non-empty range
  a_range_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (lo_r < end_r))
    else $error("probe issued on an empty range");

  // the midpoint lies inside the current range
  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (({1'b0, mid_r} >= lo_r) && ({1'b0, mid_r} < end_r)))
    else $error("midpoint outside search range");

  // a probe is always followed by its compare
  a_probe_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |=> (state_r == ST_COMPARE))
    else $error("compare did not follow probe");

  // a not-found result reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_pos_r == '0))
    else $error("not-found result with nonzero position");

  // a finished result is held while the output register stays occupied
  a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINISH) && out_valid_r && !out_rsp.ready) |=> (state_r == ST_FINISH))
    else $error("result left finish while output was full");
`endif

endmodule
